// ----- hdl/axis_pair_orthonormalizer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the axis pair orthonormalizer
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AXIS_PAIR_ORTHONORMALIZER_UNIT_DEFINES_SVH
`define AXIS_PAIR_ORTHONORMALIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define APO_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("apo assertion failed");
// Next-cycle implication.
`define APO_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("apo assertion failed");
`else
`define APO_ASSERT_IMP(lbl, ante, cons)
`define APO_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/apo_pkg.sv -----
// ----------------------------------------------------------------------------
// apo_pkg
// Shared types, constants and rounding helpers of the orthonormalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apo_pkg;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	// Command to the shared square root / divide unit.
	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} dvs_ctl_t;

	// Status of the shared square root / divide unit.
	typedef struct packed {
		logic busy;
		logic done;
	} dvs_sts_t;

	// Shift right by 14 with rounding half away from zero.
	function automatic logic signed [63:0] rnd14(input logic signed [63:0] a);
		logic [63:0] m;
		logic [63:0] r;
		m = a[63] ? (~a + 64'd1) : a;
		r = (m + 64'd8192) >> 14;
		return a[63] ? $signed(~r + 64'd1) : $signed(r);
	endfunction

endpackage

// ----- hdl/apo_divsqrt.sv -----
// ----------------------------------------------------------------------------
// apo_divsqrt
// Shared iterative unit: 64-bit floor square root (32 steps) or a 15-bit
// quotient restoring division (15 steps), one compare-subtract per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "axis_pair_orthonormalizer_unit_defines.svh"

module apo_divsqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  apo_pkg::dvs_ctl_t ctl,
	input  logic [63:0]       opa,
	input  logic [31:0]       opb,
	output apo_pkg::dvs_sts_t sts,
	output logic [63:0]       result
);
	import apo_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] aux_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        mode_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;
	logic        ge;

	// The square root compares against root + bit, the division against
	// the shifted divisor.
	assign trial = mode_q ? (aux_q + bit_q) : bit_q;
	assign ge    = (rem_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				mode_q <= ctl.sqrt_mode;
				cnt_q  <= ctl.sqrt_mode ? 5'd31 : 5'd14;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= opa;
			aux_q <= '0;
			bit_q <= ctl.sqrt_mode ? (64'd1 << 62) : {18'd0, opb, 14'd0};
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - trial;
			if (mode_q) begin
				aux_q <= ge ? ((aux_q >> 1) + bit_q) : (aux_q >> 1);
				bit_q <= bit_q >> 2;
			end else begin
				aux_q <= {aux_q[62:0], ge};
				bit_q <= bit_q >> 1;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = aux_q;

	`APO_ASSERT_IMP(a_no_start_busy, ctl.start, !busy_q)
	`APO_ASSERT_IMP(a_done_not_busy, done_q, !busy_q)
	`APO_ASSERT_NXT(a_done_idle_next, done_q, !busy_q)

endmodule

// ----- hdl/axis_pair_orthonormalizer_unit.sv -----
// ----------------------------------------------------------------------------
// axis_pair_orthonormalizer_unit
// Keeps a unit primary and secondary axis pair in Q1.14 and reports the frame.
// ----------------------------------------------------------------------------
// Usage: an input transfer (in_valid high, in_stall low) carries a request type
// and a primary and a secondary vector in Q8.16. Type 0 sets the primary, 1 the
// secondary, 2 both with the primary first; type 3 only reports. Each input
// transfer produces exactly one output transfer holding the stored primary,
// the stored secondary, their cross product and two ignore flags.
// in_stall is high whenever the sequencer is busy, so one item is worked on at
// a time. The work runs on one shared 32x32 multiplier and one shared
// square root / divider unit. Each vector normalization forms the sum of
// squares, starts the root, waits for the square root, checks the length and
// runs three divides, one per component. A report only computes the cross
// product of the stored axes; the longest item sets both vectors and needs
// the fallback axis at every step.
// The result sits in an output register: while the receiver holds out_stall,
// the block still accepts and processes the next item and only waits at the
// very end until the output register is free again.
// Reset restores the configuration registers to their defaults and the frame to
// primary = unit X, secondary = unit Y. Configuration is written over the APB
// port, registers at byte addresses 0, 4 and 8; pready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "axis_pair_orthonormalizer_unit_defines.svh"

module axis_pair_orthonormalizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [23:0] primary_in_x,
	input  logic signed [23:0] primary_in_y,
	input  logic signed [23:0] primary_in_z,
	input  logic signed [23:0] secondary_in_x,
	input  logic signed [23:0] secondary_in_y,
	input  logic signed [23:0] secondary_in_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] primary_out_x,
	output logic signed [15:0] primary_out_y,
	output logic signed [15:0] primary_out_z,
	output logic signed [15:0] secondary_out_x,
	output logic signed [15:0] secondary_out_y,
	output logic signed [15:0] secondary_out_z,
	output logic signed [15:0] third_out_x,
	output logic signed [15:0] third_out_y,
	output logic signed [15:0] third_out_z,
	output logic               primary_ignored,
	output logic               secondary_ignored
);
	import apo_pkg::*;

	localparam logic [1:0] REG_PMIN = 2'd0;
	localparam logic [1:0] REG_SMIN = 2'd1;
	localparam logic [1:0] REG_PLIM = 2'd2;

	localparam logic [1:0] REQ_PRI  = 2'd0;
	localparam logic [1:0] REQ_SEC  = 2'd1;
	localparam logic [1:0] REQ_BOTH = 2'd2;

	// Largest |p_y| for which 2*p_y^2 stays below 2^28.
	localparam logic [14:0] PY_LIMIT = 15'd11585;

	typedef enum logic [13:0] {
		ST_IDLE      = 14'b00000000000001,
		ST_START     = 14'b00000000000010,
		ST_AFTER_P   = 14'b00000000000100,
		ST_MAC_MUL   = 14'b00000000001000,
		ST_MAC_ACC   = 14'b00000000010000,
		ST_MAC_END   = 14'b00000000100000,
		ST_SQRT_WAIT = 14'b00000001000000,
		ST_CHECK     = 14'b00000010000000,
		ST_DIV_START = 14'b00000100000000,
		ST_DIV_WAIT  = 14'b00001000000000,
		ST_FB        = 14'b00010000000000,
		ST_SEC_DONE  = 14'b00100000000000,
		ST_THIRD     = 14'b01000000000000,
		ST_OUT       = 14'b10000000000000
	} state_t;

	// What the vector in vec_q is being normalized for.
	typedef enum logic [2:0] {
		CTX_P,   // new primary
		CTX_SI,  // secondary from the input
		CTX_SS,  // stored secondary after a new primary
		CTX_W,   // projected secondary
		CTX_F    // fallback secondary
	} ctx_t;

	// What the multiply-accumulate loop computes.
	typedef enum logic [2:0] {
		K_SQ,    // sum of squares of vec_q
		K_DOT,   // u . p
		K_PROJ,  // u*2^14 - rnd(d*p)
		K_CRF,   // p x t
		K_CRT    // p x s
	} kind_t;

	state_t             state_q;
	ctx_t               ctx_q;
	kind_t              kind_q;
	logic [15:0]        pmin_q;
	logic [15:0]        smin_q;
	logic [14:0]        plim_q;
	logic signed [15:0] p_q [3];
	logic signed [15:0] s_q [3];
	logic signed [15:0] u_q [3];
	logic signed [15:0] t_q [3];
	logic signed [23:0] sv_q [3];
	logic signed [31:0] vec_q [3];
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] d_q;
	logic [31:0]        len_q;
	logic [1:0]         idx_q;
	logic [2:0]         term_q;
	logic [1:0]         req_q;
	logic               pign_q;
	logic               sign_q;
	logic               sec_int_q;

	dvs_ctl_t           dvs_ctl;
	dvs_sts_t           dvs_sts;
	logic [63:0]        dvs_opa;
	logic [63:0]        dvs_res;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	logic [1:0]         ci;
	logic [1:0]         cj;
	logic [1:0]         ck;
	logic signed [15:0] crs_b [3];
	logic [2:0]         last_term;
	logic               in_accept;
	logic               out_load;
	logic               cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == ST_OUT) && (!out_valid || !out_stall);

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q <= 16'd7;
			smin_q <= 16'd1;
			plim_q <= 15'd16368;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_PMIN: pmin_q <= pwdata[15:0];
				REG_SMIN: smin_q <= pwdata[15:0];
				REG_PLIM: plim_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PMIN: prdata = {16'd0, pmin_q};
			REG_SMIN: prdata = {16'd0, smin_q};
			REG_PLIM: prdata = {17'd0, plim_q};
			default:  prdata = 32'd0;
		endcase
	end

	// ---------------- shared multiplier operand selection ----------------
	// Cross product component ci uses the two other axes cj and ck.
	assign ci = term_q[2:1];
	always_comb begin
		case (ci)
			2'd0:    begin cj = 2'd1; ck = 2'd2; end
			2'd1:    begin cj = 2'd2; ck = 2'd0; end
			default: begin cj = 2'd0; ck = 2'd1; end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) crs_b[i] = (kind_q == K_CRT) ? s_q[i] : t_q[i];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (kind_q)
			K_SQ: begin
				mul_a = vec_q[term_q[1:0]];
				mul_b = vec_q[term_q[1:0]];
			end
			K_DOT: begin
				mul_a = 32'(u_q[term_q[1:0]]);
				mul_b = 32'(p_q[term_q[1:0]]);
			end
			K_PROJ: begin
				mul_a = d_q;
				mul_b = 32'(p_q[term_q[1:0]]);
			end
			default: begin
				mul_a = term_q[0] ? 32'(p_q[ck]) : 32'(p_q[cj]);
				mul_b = term_q[0] ? 32'(crs_b[cj]) : 32'(crs_b[ck]);
			end
		endcase
	end

	assign mul_p     = mul_a * mul_b;
	assign last_term = (kind_q == K_CRF || kind_q == K_CRT) ? 3'd5 : 3'd2;

	// ---------------- shared square root / divide unit ----------------
	logic [31:0] vmag;
	assign vmag = vec_q[idx_q][31] ? (~vec_q[idx_q] + 32'd1) : vec_q[idx_q];

	assign dvs_ctl.start     = ((state_q == ST_MAC_END) && (kind_q == K_SQ)) ||
	                           (state_q == ST_DIV_START);
	assign dvs_ctl.sqrt_mode = (state_q == ST_MAC_END);
	assign dvs_opa = (state_q == ST_DIV_START) ?
	                 (({32'd0, vmag} << 14) + {33'd0, len_q[31:1]}) : acc_q;

	apo_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dvs_ctl),
		.opa    (dvs_opa),
		.opb    (len_q),
		.sts    (dvs_sts),
		.result (dvs_res)
	);

	// ---------------- decisions ----------------
	logic               len_short;
	logic signed [63:0] cos_r;
	logic [63:0]        cos_mag;
	logic [14:0]        apx;
	logic [14:0]        apy;
	logic [14:0]        apz;
	logic [19:0]        fb_lhs;
	logic [19:0]        fb_rhs;
	logic signed [15:0] qsig;

	always_comb begin
		len_short = (len_q == 32'd0) ||
		            (len_q < {16'd0, (ctx_q == CTX_P) ? pmin_q : smin_q});
		cos_r   = rnd14(acc_q);
		cos_mag = cos_r[63] ? (~cos_r + 64'd1) : cos_r;
		apx     = p_q[0][15] ? 15'(-p_q[0]) : p_q[0][14:0];
		apy     = p_q[1][15] ? 15'(-p_q[1]) : p_q[1][14:0];
		apz     = p_q[2][15] ? 15'(-p_q[2]) : p_q[2][14:0];
		fb_lhs  = 20'(apx) * 20'd10 + 20'd16384;
		fb_rhs  = 20'(apz) * 20'd10;
		qsig    = vec_q[idx_q][31] ? -$signed({1'b0, dvs_res[14:0]}) :
		                             $signed({1'b0, dvs_res[14:0]});
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ctx_q     <= CTX_P;
			kind_q    <= K_SQ;
			idx_q     <= '0;
			term_q    <= '0;
			req_q     <= '0;
			pign_q    <= 1'b0;
			sign_q    <= 1'b0;
			sec_int_q <= 1'b0;
			out_valid <= 1'b0;
			p_q[0] <= ONE_Q14; p_q[1] <= '0;      p_q[2] <= '0;
			s_q[0] <= '0;      s_q[1] <= ONE_Q14; s_q[2] <= '0;
		end else begin
			if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						req_q  <= req_type;
						pign_q <= 1'b0;
						sign_q <= 1'b0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (req_q == REQ_PRI || req_q == REQ_BOTH) begin
						ctx_q   <= CTX_P;
						kind_q  <= K_SQ;
						term_q  <= '0;
						state_q <= ST_MAC_MUL;
					end else begin
						state_q <= ST_AFTER_P;
					end
				end
				ST_AFTER_P: begin
					term_q <= '0;
					state_q <= ST_MAC_MUL;
					if (req_q == REQ_SEC || req_q == REQ_BOTH) begin
						ctx_q     <= CTX_SI;
						sec_int_q <= 1'b0;
						kind_q    <= K_SQ;
					end else begin
						kind_q <= K_CRT;
					end
				end
				ST_MAC_MUL: state_q <= ST_MAC_ACC;
				ST_MAC_ACC: begin
					if (term_q == last_term) begin
						state_q <= ST_MAC_END;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= ST_MAC_MUL;
					end
				end
				ST_MAC_END: begin
					term_q <= '0;
					case (kind_q)
						K_SQ: state_q <= ST_SQRT_WAIT;
						K_DOT: begin
							if (cos_mag < {49'd0, plim_q}) begin
								kind_q  <= K_PROJ;
								state_q <= ST_MAC_MUL;
							end else begin
								state_q <= ST_FB;
							end
						end
						K_PROJ: begin
							ctx_q   <= CTX_W;
							kind_q  <= K_SQ;
							state_q <= ST_MAC_MUL;
						end
						K_CRF: begin
							ctx_q   <= CTX_F;
							kind_q  <= K_SQ;
							state_q <= ST_MAC_MUL;
						end
						default: state_q <= ST_THIRD;
					endcase
				end
				ST_SQRT_WAIT: begin
					if (dvs_sts.done) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					idx_q <= '0;
					case (ctx_q) inside
						CTX_P: begin
							if (len_short) begin
								pign_q  <= 1'b1;
								state_q <= ST_AFTER_P;
							end else begin
								state_q <= ST_DIV_START;
							end
						end
						CTX_SI, CTX_SS: begin
							if (len_short) begin
								if (ctx_q == CTX_SI) sign_q <= 1'b1;
								state_q <= ST_SEC_DONE;
							end else begin
								state_q <= ST_DIV_START;
							end
						end
						CTX_W: state_q <= (len_q == 32'd0) ? ST_FB : ST_DIV_START;
						default: state_q <= (len_q == 32'd0) ? ST_SEC_DONE : ST_DIV_START;
					endcase
				end
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (dvs_sts.done) begin
						case (ctx_q) inside
							CTX_P:          p_q[idx_q] <= qsig;
							CTX_SI, CTX_SS: u_q[idx_q] <= qsig;
							default:        s_q[idx_q] <= qsig;
						endcase
						if (idx_q != 2'd2) begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_DIV_START;
						end else begin
							term_q <= '0;
							case (ctx_q) inside
								CTX_P: begin
									ctx_q     <= CTX_SS;
									sec_int_q <= 1'b1;
									kind_q    <= K_SQ;
									state_q   <= ST_MAC_MUL;
								end
								CTX_SI, CTX_SS: begin
									kind_q  <= K_DOT;
									state_q <= ST_MAC_MUL;
								end
								default: state_q <= ST_SEC_DONE;
							endcase
						end
					end
				end
				ST_FB: begin
					kind_q  <= K_CRF;
					term_q  <= '0;
					state_q <= ST_MAC_MUL;
				end
				ST_SEC_DONE: begin
					if (sec_int_q) begin
						sec_int_q <= 1'b0;
						state_q   <= ST_AFTER_P;
					end else begin
						kind_q  <= K_CRT;
						term_q  <= '0;
						state_q <= ST_MAC_MUL;
					end
				end
				ST_THIRD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_accept) begin
			vec_q[0] <= 32'(primary_in_x);
			vec_q[1] <= 32'(primary_in_y);
			vec_q[2] <= 32'(primary_in_z);
			sv_q[0]  <= secondary_in_x;
			sv_q[1]  <= secondary_in_y;
			sv_q[2]  <= secondary_in_z;
		end
		if (state_q == ST_AFTER_P && (req_q == REQ_SEC || req_q == REQ_BOTH)) begin
			for (int i = 0; i < 3; i++) vec_q[i] <= 32'(sv_q[i]);
		end
		// The stored secondary is renormalized in Q8.16, that is times four.
		if (state_q == ST_DIV_WAIT && dvs_sts.done && idx_q == 2'd2 && ctx_q == CTX_P) begin
			for (int i = 0; i < 3; i++) vec_q[i] <= 32'(s_q[i]) <<< 2;
		end
		if (state_q == ST_SQRT_WAIT && dvs_sts.done) len_q <= dvs_res[31:0];
		if (state_q == ST_MAC_END && kind_q == K_DOT) d_q <= acc_q[31:0];
		if (state_q == ST_MAC_ACC) begin
			case (kind_q) inside
				K_SQ, K_DOT: acc_q <= ((term_q == 3'd0) ? 64'sd0 : acc_q) + prod_q;
				K_PROJ: begin
					vec_q[term_q[1:0]] <=
						32'((64'(u_q[term_q[1:0]]) <<< 14) - rnd14(prod_q));
				end
				default: begin
					if (!term_q[0]) acc_q <= prod_q;
					else vec_q[ci] <= 32'(acc_q - prod_q);
				end
			endcase
		end
		// Fallback helper t = e x p, with e picked from the primary's direction.
		if (state_q == ST_FB) begin
			if (apy <= PY_LIMIT) begin
				t_q[0] <= p_q[2]; t_q[1] <= '0;     t_q[2] <= -p_q[0];
			end else if (fb_lhs > fb_rhs) begin
				t_q[0] <= -p_q[1]; t_q[1] <= p_q[0]; t_q[2] <= '0;
			end else begin
				t_q[0] <= '0;     t_q[1] <= -p_q[2]; t_q[2] <= p_q[1];
			end
		end
		if (state_q == ST_THIRD) begin
			for (int i = 0; i < 3; i++) begin
				if (rnd14(64'(vec_q[i])) > 64'sd16384)       vec_q[i] <= 32'sd16384;
				else if (rnd14(64'(vec_q[i])) < -64'sd16384) vec_q[i] <= -32'sd16384;
				else vec_q[i] <= 32'(rnd14(64'(vec_q[i])));
			end
		end
		if (out_load) begin
			primary_out_x     <= p_q[0];
			primary_out_y     <= p_q[1];
			primary_out_z     <= p_q[2];
			secondary_out_x   <= s_q[0];
			secondary_out_y   <= s_q[1];
			secondary_out_z   <= s_q[2];
			third_out_x       <= vec_q[0][15:0];
			third_out_y       <= vec_q[1][15:0];
			third_out_z       <= vec_q[2][15:0];
			primary_ignored   <= pign_q;
			secondary_ignored <= sign_q;
		end
	end

	`APO_ASSERT_IMP(a_out_from_seq, $rose(out_valid), $past(state_q == ST_OUT))
	`APO_ASSERT_IMP(a_dvs_done_wait, dvs_sts.done,
		(state_q == ST_SQRT_WAIT) || (state_q == ST_DIV_WAIT))
	`APO_ASSERT_IMP(a_primary_range, state_q == ST_IDLE,
		(p_q[0] <= ONE_Q14) && (p_q[0] >= -ONE_Q14))

endmodule

// ----- tb/axis_pair_orthonormalizer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// axis_pair_orthonormalizer_unit_tb
// Self-checking bench for the axis pair orthonormalizer. Directed and random
// requests are driven under several idling phases and register settings. A
// bit-exact frame predictor computes the expected result of every transfer,
// and a checker compares each output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_pair_orthonormalizer_unit_tb;

	import apo_pkg::*;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_PRIMARY   = 2'd0;
	localparam logic [1:0] REQ_SECONDARY = 2'd1;
	localparam logic [1:0] REQ_BOTH      = 2'd2;
	localparam logic [1:0] REQ_REPORT    = 2'd3;

	// Register byte addresses on the APB port.
	localparam logic [3:0] REG_PRIMARY_MIN   = 4'd0;
	localparam logic [3:0] REG_SECONDARY_MIN = 4'd4;
	localparam logic [3:0] REG_PARALLEL_LIM  = 4'd8;

	// An item can run the full fallback path and the receiver can stall for long
	// stretches, so the watchdog allows generous quiet time between transfers.
	localparam int unsigned QUIET_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]         req;
		logic signed [23:0] px, py, pz, sx, sy, sz;
	} request_t;

	typedef struct packed {
		logic signed [15:0] px, py, pz, sx, sy, sz, tx, ty, tz;
		logic               pign, sign;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic signed [23:0] primary_in_x = '0, primary_in_y = '0, primary_in_z = '0;
	logic signed [23:0] secondary_in_x = '0, secondary_in_y = '0, secondary_in_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] primary_out_x, primary_out_y, primary_out_z;
	logic signed [15:0] secondary_out_x, secondary_out_y, secondary_out_z;
	logic signed [15:0] third_out_x, third_out_y, third_out_z;
	logic primary_ignored, secondary_ignored;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	axis_pair_orthonormalizer_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.primary_in_x(primary_in_x), .primary_in_y(primary_in_y),
		.primary_in_z(primary_in_z), .secondary_in_x(secondary_in_x),
		.secondary_in_y(secondary_in_y), .secondary_in_z(secondary_in_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.primary_out_x(primary_out_x), .primary_out_y(primary_out_y),
		.primary_out_z(primary_out_z), .secondary_out_x(secondary_out_x),
		.secondary_out_y(secondary_out_y), .secondary_out_z(secondary_out_z),
		.third_out_x(third_out_x), .third_out_y(third_out_y),
		.third_out_z(third_out_z), .primary_ignored(primary_ignored),
		.secondary_ignored(secondary_ignored)
	);

	// ------------------------------------------------------------------------
	// Frame predictor. It keeps its own copy of the stored axes and of the
	// three registers, all in plain 64-bit integer arithmetic.
	// ------------------------------------------------------------------------
	longint unsigned min_primary_len, min_secondary_len, cos_limit;
	longint axis_p[3], axis_s[3];
	frame_t expected_frames[$];

	int unsigned error_count, input_count, result_count, quiet_cycles;
	int unsigned sender_idle_pct, receiver_stall_pct;
	int unsigned fallback_count, pignored_count, signored_count;

	function automatic longint unsigned magnitude(longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	function automatic longint round_q14(longint a);
		longint unsigned r;
		r = (magnitude(a) + 64'd8192) >> 14;
		return a < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned vec_length(longint v[3]);
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < 3; i++) acc += magnitude(v[i]) * magnitude(v[i]);
		return floor_sqrt(acc);
	endfunction

	// Scales v to unit length in Q1.14; false when the length is zero.
	function automatic bit to_unit(longint v[3], longint unsigned len, output longint u[3]);
		longint unsigned q;
		u = '{0, 0, 0};
		if (len == 0) return 1'b0;
		for (int i = 0; i < 3; i++) begin
			q = (magnitude(v[i]) * 16384 + len / 2) / len;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic void cross3(longint a[3], longint b[3], output longint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// Takes a Q8.16 secondary; returns 1 when it is too short to use.
	function automatic bit apply_secondary(longint v[3]);
		longint u[3], w[3], e[3], t[3], f[3], res[3];
		longint d;
		longint unsigned len;
		len = vec_length(v);
		if (len == 0 || len < min_secondary_len) return 1'b1;
		void'(to_unit(v, len, u));
		d = u[0] * axis_p[0] + u[1] * axis_p[1] + u[2] * axis_p[2];
		if (magnitude(round_q14(d)) < cos_limit) begin
			for (int i = 0; i < 3; i++) w[i] = u[i] * 16384 - round_q14(d * axis_p[i]);
			if (to_unit(w, vec_length(w), res)) begin
				axis_s = res;
				return 1'b0;
			end
		end
		// Nearly parallel or degenerate projection: build a perpendicular from
		// the Y, Z or X unit axis depending on where the primary points.
		fallback_count++;
		e = '{0, 0, 0};
		if (2 * axis_p[1] * axis_p[1] < (64'sd1 <<< 28)) e[1] = 1;
		else if (10 * longint'(magnitude(axis_p[0])) + 16384 >
			10 * longint'(magnitude(axis_p[2]))) e[2] = 1;
		else e[0] = 1;
		cross3(e, axis_p, t);
		cross3(axis_p, t, f);
		if (to_unit(f, vec_length(f), res)) axis_s = res;
		return 1'b0;
	endfunction

	function automatic bit apply_primary(longint v[3]);
		longint unsigned len;
		longint s[3], u[3];
		len = vec_length(v);
		if (len == 0 || len < min_primary_len) return 1'b1;
		void'(to_unit(v, len, u));
		axis_p = u;
		for (int i = 0; i < 3; i++) s[i] = axis_s[i] * 4;
		void'(apply_secondary(s));
		return 1'b0;
	endfunction

	function automatic frame_t predict_frame(request_t r);
		frame_t fr;
		longint pv[3], sv[3], t[3], c[3];
		pv = '{longint'(r.px), longint'(r.py), longint'(r.pz)};
		sv = '{longint'(r.sx), longint'(r.sy), longint'(r.sz)};
		fr.pign = 1'b0;
		fr.sign = 1'b0;
		if (r.req == REQ_PRIMARY || r.req == REQ_BOTH) fr.pign = apply_primary(pv);
		if (r.req == REQ_SECONDARY || r.req == REQ_BOTH) fr.sign = apply_secondary(sv);
		cross3(axis_p, axis_s, t);
		for (int i = 0; i < 3; i++) begin
			c[i] = round_q14(t[i]);
			if (c[i] > 16384) c[i] = 16384;
			if (c[i] < -16384) c[i] = -16384;
		end
		fr.px = 16'(axis_p[0]); fr.py = 16'(axis_p[1]); fr.pz = 16'(axis_p[2]);
		fr.sx = 16'(axis_s[0]); fr.sy = 16'(axis_s[1]); fr.sz = 16'(axis_s[2]);
		fr.tx = 16'(c[0]); fr.ty = 16'(c[1]); fr.tz = 16'(c[2]);
		return fr;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Every accepted output transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (expected_frames.size() == 0) begin
				report_mismatch("unexpected output transfer", 1, 0);
			end else begin
				want = expected_frames.pop_front();
				if (primary_out_x !== want.px) report_mismatch("primary_out_x", primary_out_x, want.px);
				if (primary_out_y !== want.py) report_mismatch("primary_out_y", primary_out_y, want.py);
				if (primary_out_z !== want.pz) report_mismatch("primary_out_z", primary_out_z, want.pz);
				if (secondary_out_x !== want.sx)
					report_mismatch("secondary_out_x", secondary_out_x, want.sx);
				if (secondary_out_y !== want.sy)
					report_mismatch("secondary_out_y", secondary_out_y, want.sy);
				if (secondary_out_z !== want.sz)
					report_mismatch("secondary_out_z", secondary_out_z, want.sz);
				if (third_out_x !== want.tx) report_mismatch("third_out_x", third_out_x, want.tx);
				if (third_out_y !== want.ty) report_mismatch("third_out_y", third_out_y, want.ty);
				if (third_out_z !== want.tz) report_mismatch("third_out_z", third_out_z, want.tz);
				if (primary_ignored !== want.pign)
					report_mismatch("primary_ignored", primary_ignored, want.pign);
				if (secondary_ignored !== want.sign)
					report_mismatch("secondary_ignored", secondary_ignored, want.sign);
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
			$display("axis_pair_orthonormalizer_unit_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Sends one request: optional idle gap, hold until accepted, predict.
	// in_valid stays high after the transfer; whoever waits next drops it.
	task automatic send_request(request_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.req;
		primary_in_x <= r.px; primary_in_y <= r.py; primary_in_z <= r.pz;
		secondary_in_x <= r.sx; secondary_in_y <= r.sy; secondary_in_z <= r.sz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_frames.push_back(predict_frame(r));
		if (expected_frames[$].pign) pignored_count++;
		if (expected_frames[$].sign) signored_count++;
		input_count++;
	endtask

	// Waits until every expected result has arrived, plus a short settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_register(logic [3:0] addr, logic [31:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (addr)
			REG_PRIMARY_MIN:   min_primary_len = 64'(value[15:0]);
			REG_SECONDARY_MIN: min_secondary_len = 64'(value[15:0]);
			REG_PARALLEL_LIM:  cos_limit = 64'(value[14:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(int unsigned pmin, int unsigned smin, int unsigned plim);
		wait_drained();
		write_register(REG_PRIMARY_MIN, pmin);
		write_register(REG_SECONDARY_MIN, smin);
		write_register(REG_PARALLEL_LIM, plim);
	endtask

	function automatic logic signed [23:0] random_component();
		case ($urandom_range(5))
			0: return 24'($urandom);                              // full range
			1: return 24'(int'($urandom_range(40)) - 20);         // tiny
			2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			3: return '0;
			default: return 24'(int'($urandom_range(262143)) - 131072);
		endcase
	endfunction

	function automatic request_t random_request();
		request_t r;
		r.req = $urandom_range(99) < 4 ? REQ_REPORT : 2'($urandom_range(2));
		r.px = random_component(); r.py = random_component(); r.pz = random_component();
		// A third of the secondaries are scaled copies of the primary so the
		// parallel fallback gets real exercise.
		if ($urandom_range(2) == 0) begin
			r.sx = r.px >>> $urandom_range(3);
			r.sy = r.py >>> $urandom_range(3);
			r.sz = r.pz >>> $urandom_range(3);
			if ($urandom_range(1)) begin
				r.sx = -r.sx; r.sy = -r.sy; r.sz = -r.sz;
			end
		end else begin
			r.sx = random_component(); r.sy = random_component(); r.sz = random_component();
		end
		return r;
	endfunction

	function automatic request_t make_req(logic [1:0] req, int px, int py, int pz,
		int sx, int sy, int sz);
		request_t r;
		r.req = req;
		r.px = 24'(px); r.py = 24'(py); r.pz = 24'(pz);
		r.sx = 24'(sx); r.sy = 24'(sy); r.sz = 24'(sz);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Extremes, every request code, zero and short vectors, the parallel
	// fallback along the Y and Z unit axes.
	task automatic test_directed();
		send_request(make_req(REQ_REPORT, 0, 0, 0, 0, 0, 0));
		send_request(make_req(REQ_PRIMARY, 0, 0, 0, 0, 0, 0));           // zero primary
		send_request(make_req(REQ_SECONDARY, 5, 5, 5, 0, 0, 0));         // zero secondary
		send_request(make_req(REQ_PRIMARY, 3, 2, 1, 0, 0, 0));           // too short
		send_request(make_req(REQ_PRIMARY, 8388607, 8388607, 8388607, 0, 0, 0));
		send_request(make_req(REQ_PRIMARY, -8388608, -8388608, -8388608, 0, 0, 0));
		send_request(make_req(REQ_SECONDARY, 0, 0, 0, -8388608, 8388607, -8388608));
		send_request(make_req(REQ_BOTH, 65536, 0, 0, 65536, 0, 0));      // parallel, Y axis
		send_request(make_req(REQ_BOTH, 0, 65536, 0, 0, -65536, 0));     // parallel, Z axis
		send_request(make_req(REQ_BOTH, 0, 65536, 70000, 0, 65536, 70000)); // parallel, Y axis
		send_request(make_req(REQ_BOTH, 0, 65536, 0, 0, 0, 65536));
		send_request(make_req(REQ_BOTH, 1, 0, 0, 0, 1, 0));
		send_request(make_req(REQ_BOTH, -8388608, 0, 0, 8388607, 0, 0)); // antiparallel
		send_request(make_req(REQ_BOTH, 0, 0, 0, 0, 0, 0));              // both ignored
		send_request(make_req(REQ_PRIMARY, 0, 0, -65536, 0, 0, 0));
		send_request(make_req(REQ_SECONDARY, 0, 0, 0, 1, 1, 1));
		send_request(make_req(REQ_REPORT, -1, -1, -1, -1, -1, -1));
	endtask

	task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		repeat (count) send_request(random_request());
	endtask

	// The sender holds back until the block has delivered everything.
	task automatic test_drain_pause();
		repeat (10) send_request(random_request());
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (10) send_request(random_request());
	endtask

	// Register extremes: zero minimums and parallel limit of zero (every
	// secondary falls back), then the largest minimums and a limit of one.
	task automatic test_register_extremes();
		set_config(0, 0, 0);
		test_random(60, 0, 0);
		set_config(65535, 65535, 16384);
		test_random(60, 24, 24);
		set_config(1000, 300, 12000);
		test_random(60, 75, 0);
		set_config(7, 1, 16368);
	endtask

	initial begin
		error_count = 0; input_count = 0; result_count = 0; quiet_cycles = 0;
		fallback_count = 0; pignored_count = 0; signored_count = 0;
		sender_idle_pct = 0; receiver_stall_pct = 0;
		min_primary_len = 7; min_secondary_len = 1; cos_limit = 16368;
		axis_p = '{16384, 0, 0};
		axis_s = '{0, 16384, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(150, 0, 0);
		test_random(150, 75, 0);
		test_random(150, 0, 75);
		test_random(150, 24, 24);
		test_drain_pause();
		test_register_extremes();
		test_random(50, 0, 0);

		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d requests and %0d frames across idle phases and register settings.",
			input_count, result_count);
		$display("Fallback builds %0d, ignored primaries %0d, ignored secondaries %0d.",
			fallback_count, pignored_count, signored_count);
		if (error_count == 0) begin
			$display("axis_pair_orthonormalizer_unit_tb: clean");
		end else begin
			$display("axis_pair_orthonormalizer_unit_tb: errors");
		end
		$finish;
	end

endmodule
